/* rtl/isl_pkg.sv */
// Package for the indexed shift list: sizes, opcode and status codes,
// and the control bundle that the list drives into its row of cells.
// No dependencies.
package isl_pkg;

  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 32;
  localparam int POS_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  // Request field widths
  localparam int OP_W      = 3;
  localparam int POSITION_W = 4;
  localparam int PAYLOAD_W = 32;

  // Response field widths
  localparam int DATA_W   = 32;
  localparam int ECOUNT_W = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_RM_FRONT  = 3'd3,
    OP_RM_AT     = 3'd4,
    OP_RM_BACK   = 3'd5,
    OP_READ      = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell: what moves this cycle and where it starts
  typedef struct packed {
    logic                shift_up;
    logic                shift_down;
    logic [POS_BITS-1:0] pos;
  } shift_ctrl_t;

endpackage

/* rtl/isl_in_if.sv */
// Request channel of the indexed shift list: valid/ready plus opcode,
// position and payload. Depends on isl_pkg.
interface isl_in_if;
  logic                          valid;
  logic                          ready;
  logic [isl_pkg::OP_W-1:0]       opcode;
  logic [isl_pkg::POSITION_W-1:0] position;
  logic [isl_pkg::PAYLOAD_W-1:0]  payload;

  modport source (output valid, opcode, position, payload, input ready);
  modport sink   (input valid, opcode, position, payload, output ready);
endinterface

/* rtl/isl_out_if.sv */
// Response channel of the indexed shift list: valid/ready plus read data,
// entry count and status. Depends on isl_pkg.
interface isl_out_if;
  logic                        valid;
  logic                        ready;
  logic [isl_pkg::DATA_W-1:0]   read_data;
  logic [isl_pkg::ECOUNT_W-1:0] entry_count;
  logic [isl_pkg::STATUS_W-1:0] status;

  modport source (output valid, read_data, entry_count, status, input ready);
  modport sink   (input valid, read_data, entry_count, status, output ready);
endinterface

/* rtl/isl_cell.sv */
// One slot of the shift list. Takes its left neighbor on an insert shift,
// its right neighbor on a remove shift, or the new word. Depends on isl_pkg.
module isl_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  isl_pkg::shift_ctrl_t             ctrl,
  input  logic [isl_pkg::POS_BITS-1:0]     idx,
  input  logic [isl_pkg::ENTRY_BITS-1:0]   word,
  input  logic [isl_pkg::ENTRY_BITS-1:0]   left_entry,
  input  logic [isl_pkg::ENTRY_BITS-1:0]   right_entry,
  output logic [isl_pkg::ENTRY_BITS-1:0]   entry
);

  logic [isl_pkg::ENTRY_BITS-1:0] entry_next;

  // Slot update: above the target moves, at the target loads or pulls
  always_comb begin
    entry_next = entry;
    if (ctrl.shift_up) begin
      if (idx > ctrl.pos) begin
        entry_next = left_entry;
      end else if (idx == ctrl.pos) begin
        entry_next = word;
      end
    end else if (ctrl.shift_down) begin
      if (idx >= ctrl.pos) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

/* rtl/indexed_shift_list.sv */
// Top level of the indexed shift list: count, op decode, read select,
// response register and the row of isl_cell slots.
// Depends on isl_pkg, isl_in_if, isl_out_if, isl_cell.
//
//   channel   dir   payload                              handshake
//   in_ch     in    opcode, position, payload            valid/ready
//   out_ch    out   read_data, entry_count, status       valid/ready
//
// Decode is combinational; every slot shift and the load of the response
// register happen together at the accepting edge.
// One request per cycle is sustained while out_ch takes responses; a stalled
// response holds in_ch ready low until it is taken.
// Synchronous reset empties the list and zeroes every slot; no clearing pass.
module indexed_shift_list (
  input logic       clk,
  input logic       rst,
  isl_in_if.sink    in_ch,
  isl_out_if.source out_ch
);

  logic [isl_pkg::ENTRY_BITS-1:0] entries [isl_pkg::DEPTH];
  logic [isl_pkg::COUNT_BITS-1:0] count;
  logic [isl_pkg::COUNT_BITS-1:0] count_next;

  logic                           accept;
  logic [isl_pkg::COUNT_BITS-1:0] pos_ext;
  logic [isl_pkg::COUNT_BITS-1:0] tpos;
  logic                           do_ins;
  logic                           do_rm;
  logic                           full;
  logic                           empty;
  isl_pkg::status_t               status_next;
  logic [isl_pkg::DATA_W-1:0]     rdata_next;
  isl_pkg::shift_ctrl_t           ctrl;
  logic [isl_pkg::ENTRY_BITS-1:0] word;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_ext     = isl_pkg::COUNT_BITS'(in_ch.position);
  assign full        = (count == isl_pkg::COUNT_BITS'(isl_pkg::DEPTH));
  assign empty       = (count == '0);
  assign word        = in_ch.payload[isl_pkg::ENTRY_BITS-1:0];

  // Op decode: refusals first, then target slot of the shift
  always_comb begin
    do_ins      = 1'b0;
    do_rm       = 1'b0;
    tpos        = '0;
    status_next = isl_pkg::ST_OK;
    rdata_next  = '0;
    unique case (isl_pkg::op_t'(in_ch.opcode))
      isl_pkg::OP_INS_FRONT, isl_pkg::OP_INS_AT, isl_pkg::OP_INS_BACK: begin
        if (full) begin
          status_next = isl_pkg::ST_FULL;
        end else if (isl_pkg::op_t'(in_ch.opcode) == isl_pkg::OP_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (isl_pkg::op_t'(in_ch.opcode) == isl_pkg::OP_INS_BACK) begin
          do_ins = 1'b1;
          tpos   = count;
        end else if (pos_ext > count) begin
          status_next = isl_pkg::ST_RANGE;
        end else begin
          do_ins = 1'b1;
          tpos   = pos_ext;
        end
      end
      isl_pkg::OP_RM_FRONT, isl_pkg::OP_RM_AT, isl_pkg::OP_RM_BACK: begin
        if (empty) begin
          status_next = isl_pkg::ST_EMPTY;
        end else if (isl_pkg::op_t'(in_ch.opcode) == isl_pkg::OP_RM_FRONT) begin
          do_rm = 1'b1;
        end else if (isl_pkg::op_t'(in_ch.opcode) == isl_pkg::OP_RM_BACK) begin
          do_rm = 1'b1;
          tpos  = count - isl_pkg::COUNT_BITS'(1);
        end else if (pos_ext >= count) begin
          status_next = isl_pkg::ST_RANGE;
        end else begin
          do_rm = 1'b1;
          tpos  = pos_ext;
        end
      end
      isl_pkg::OP_READ: begin
        if (pos_ext >= count) begin
          status_next = isl_pkg::ST_RANGE;
        end else begin
          rdata_next = isl_pkg::DATA_W'(entries[pos_ext[isl_pkg::POS_BITS-1:0]]);
        end
      end
      default: begin
      end
    endcase
  end

  // Count update
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + isl_pkg::COUNT_BITS'(1);
    end else if (do_rm) begin
      count_next = count - isl_pkg::COUNT_BITS'(1);
    end
  end

  assign ctrl.shift_up   = accept && do_ins;
  assign ctrl.shift_down = accept && do_rm;
  assign ctrl.pos        = tpos[isl_pkg::POS_BITS-1:0];

  // Row of slots; the ends see zero from outside
  for (genvar i = 0; i < isl_pkg::DEPTH; i++) begin : g_cell
    logic [isl_pkg::ENTRY_BITS-1:0] left_entry;
    logic [isl_pkg::ENTRY_BITS-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_mid_left
      assign left_entry = entries[i-1];
    end

    if (i == isl_pkg::DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid_right
      assign right_entry = entries[i+1];
    end

    isl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .idx         (isl_pkg::POS_BITS'(i)),
      .word        (word),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i])
    );
  end

  // Count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        count        <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.read_data   <= rdata_next;
      out_ch.entry_count <= isl_pkg::ECOUNT_W'(count_next);
      out_ch.status      <= status_next;
    end
  end

endmodule

/* sim/isl_list_checker.sv */
`timescale 1ns / 100ps
// Response checker for the indexed shift list: watches both channels, keeps
// its own copy of the list, and compares every response with its prediction.
// Depends on isl_pkg, isl_in_if and isl_out_if.
module isl_list_checker
  import isl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  isl_in_if         req_ch,
  isl_out_if        rsp_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [ECOUNT_W-1:0] entry_count;
    status_t             status;
  } list_resp_t;

  // Shadow copy of the list contents and length
  logic [ENTRY_BITS-1:0] slot_words [DEPTH];
  int                    slot_count;
  list_resp_t            resp_fifo [$];

  // Apply one request to the shadow list and return the response it gives
  function automatic list_resp_t apply_request(op_t op, logic [POSITION_W-1:0] pos,
                                               logic [PAYLOAD_W-1:0] word);
    list_resp_t r;
    int         at;
    r.read_data   = '0;
    r.status      = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: begin
        // full is checked ahead of the position
        if (slot_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_INS_AT && int'(pos) > slot_count) begin
          r.status = ST_RANGE;
        end else begin
          at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? slot_count : int'(pos);
          for (int i = slot_count; i > at; i--) slot_words[i] = slot_words[i-1];
          slot_words[at] = word[ENTRY_BITS-1:0];
          slot_count++;
        end
      end
      OP_RM_FRONT, OP_RM_AT, OP_RM_BACK: begin
        // empty is checked ahead of the position
        if (slot_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_RM_AT && int'(pos) >= slot_count) begin
          r.status = ST_RANGE;
        end else begin
          at = (op == OP_RM_FRONT) ? 0 : (op == OP_RM_BACK) ? slot_count - 1 : int'(pos);
          for (int i = at; i + 1 < slot_count; i++) slot_words[i] = slot_words[i+1];
          slot_words[slot_count-1] = '0;  // freed top slot reads back as zero
          slot_count--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= slot_count) r.status = ST_RANGE;
        else r.read_data = DATA_W'(slot_words[pos]);
      end
      default: ;  // unused opcode: no change
    endcase
    r.entry_count = ECOUNT_W'(slot_count);
    return r;
  endfunction

  assign pending = resp_fifo.size();

  // Responses are checked before the request of the same edge is predicted
  always @(posedge clk) begin
    list_resp_t want;
    if (rst) begin
      foreach (slot_words[i]) slot_words[i] = '0;
      slot_count = 0;
      resp_fifo.delete();
      fail_count <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (resp_fifo.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: response with none outstanding: data %08h count %0d status %0d",
                     $realtime, rsp_ch.read_data, rsp_ch.entry_count, rsp_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_fifo.pop_front();
          if (rsp_ch.read_data !== want.read_data || rsp_ch.entry_count !== want.entry_count ||
              rsp_ch.status !== want.status) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected data %08h count %0d status %0d, got %08h %0d %0d",
                       $realtime, want.read_data, want.entry_count, want.status,
                       rsp_ch.read_data, rsp_ch.entry_count, rsp_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        resp_fifo.push_back(apply_request(op_t'(req_ch.opcode), req_ch.position, req_ch.payload));
    end
  end

endmodule

/* sim/tb_indexed_shift_list.sv */
`timescale 1ns / 100ps
// Testbench top for the indexed shift list: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on isl_pkg, isl_in_if, isl_out_if, indexed_shift_list, isl_list_checker.
module tb_indexed_shift_list;
  import isl_pkg::*;

  localparam int RANDOM_REQS = 1030;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  logic burst_mode;
  int   fail_count;
  int   pending;
  int   quiet_cycles;

  isl_in_if  req_ch ();
  isl_out_if rsp_ch ();

  indexed_shift_list dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  isl_list_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_ch),
    .rsp_ch     (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Response back-pressure, off during the burst window
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= burst_mode || ($urandom_range(0, 99) >= 31);
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one request after a random idle gap (none in burst mode) and hold it until taken
  task automatic send_request(input op_t op, input logic [POSITION_W-1:0] pos,
                              input logic [PAYLOAD_W-1:0] word);
    while (!burst_mode && $urandom_range(0, 99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.position <= pos;
    req_ch.payload  <= word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    int   bias;
    int   pick;
    op_t  op;
    logic [POSITION_W-1:0] pos;
    logic [PAYLOAD_W-1:0]  word;
    rst             = 1'b1;
    burst_mode      <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.opcode   <= OP_NOP;
    req_ch.position <= '0;
    req_ch.payload  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, range errors, every op, payload extremes
    send_request(OP_READ,      4'd0,  32'h0);
    send_request(OP_RM_FRONT,  4'd0,  32'h0);
    send_request(OP_RM_AT,     4'd0,  32'h0);
    send_request(OP_RM_BACK,   4'd0,  32'h0);
    send_request(OP_NOP,       4'd0,  32'h0);
    send_request(OP_INS_AT,    4'd1,  32'hDEAD_BEEF);   // past the count
    send_request(OP_INS_FRONT, 4'd0,  32'hFFFF_FFFF);
    send_request(OP_INS_BACK,  4'd0,  32'h0);
    send_request(OP_INS_AT,    4'd2,  32'hA5A5_5A5A);   // at the count: appends
    send_request(OP_INS_AT,    4'd0,  32'h1234_5678);
    send_request(OP_READ,      4'd0,  32'h0);
    send_request(OP_READ,      4'd3,  32'h0);
    send_request(OP_READ,      4'd4,  32'h0);
    send_request(OP_READ,      4'd15, 32'h0);
    send_request(OP_INS_AT,    4'd15, 32'h5A5A_A5A5);
    send_request(OP_RM_AT,     4'd4,  32'h0);
    send_request(OP_RM_AT,     4'd1,  32'h0);
    send_request(OP_RM_BACK,   4'd0,  32'h0);
    send_request(OP_RM_FRONT,  4'd0,  32'h0);
    send_request(OP_NOP,       4'd15, 32'hFFFF_FFFF);
    send_request(OP_READ,      4'd0,  32'h0);

    // Random: phases that fill, mix and drain the list in turn
    for (int n = 0; n < RANDOM_REQS; n++) begin
      burst_mode <= (n >= 400 && n < 600);
      case ((n / 80) % 3)
        0:       bias = 70;  // mostly inserts, runs into full
        1:       bias = 40;
        default: bias = 15;  // mostly removes, runs into empty
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_NOP;
      else if (pick < 3 + bias) op = op_t'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
      else if (pick < 85) op = op_t'($urandom_range(OP_RM_FRONT, OP_RM_BACK));
      else op = OP_READ;
      pos = $urandom_range(0, 1) ? POSITION_W'($urandom_range(0, 15))
                                 : POSITION_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      send_request(op, pos, word);
    end
    burst_mode   <= 1'b0;
    req_ch.valid <= 1'b0;

    // Let the checker log the last request, drain, then allow for stray ones
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/isl_pkg.sv
rtl/isl_in_if.sv
rtl/isl_out_if.sv
rtl/isl_cell.sv
rtl/indexed_shift_list.sv
sim/isl_list_checker.sv
sim/tb_indexed_shift_list.sv
